// ===== rtl/core/command_retransmit_cache_top_defines.svh =====
// Assertion macros used by the retransmit cache checker.
`ifndef COMMAND_RETRANSMIT_CACHE_TOP_DEFINES_SVH
`define COMMAND_RETRANSMIT_CACHE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CMDRC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmdrc same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CMDRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmdrc next-cycle check failed");

`endif

// ===== rtl/core/cmdrc_pkg.sv =====
// Shared constants and controller/datapath types for the retransmit cache.
`timescale 1ns / 1ps

package cmdrc_pkg;

    localparam int ENTRIES = 5;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef logic [IDX_W-1:0] idx_t;

    localparam idx_t LAST_IDX = idx_t'(ENTRIES - 1);
    localparam logic [31:0] TAG_LIMIT = 32'd256;
    localparam logic [7:0] DROP_AGE_RESET = 8'd3;

    // Source of the next output beat.
    typedef enum logic [1:0] {
        OSEL_ACK,
        OSEL_CMD,
        OSEL_PEND_MID,
        OSEL_PEND_LAST
    } osel_t;

    typedef struct packed {
        logic  load;
        logic  step;
        logic  clear_entry;
        logic  store_entry;
        logic  take_pend;
        logic  push;
        osel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic is_scan;
        logic is_tag;
        logic idx_last;
        logic hit_ack;
        logic hit_cmd;
        logic tmo_drop;
        logic tmo_resend;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/core/cmdrc_if.sv =====
// Valid/ready channel interfaces for notification input and result output.
`timescale 1ns / 1ps

interface cmdrc_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] value;
    logic [31:0] now;

    modport source (output valid, kind, value, now, input ready);
    modport sink (input valid, kind, value, now, output ready);
endinterface

interface cmdrc_out_if;
    logic        valid;
    logic        ready;
    logic        dest;
    logic [31:0] word;
    logic        last;

    modport source (output valid, dest, word, last, input ready);
    modport sink (input valid, dest, word, last, output ready);
endinterface

// ===== rtl/core/cmdrc_ctrl.sv =====
// Controller state machine that sequences the walk over the cache entries.
`timescale 1ns / 1ps

module cmdrc_ctrl
    import cmdrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ACK,
        S_ACK_OUT,
        S_CMD_OUT,
        S_CMD,
        S_TMO,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.sel = OSEL_ACK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.is_scan)
                begin
                    state_next = S_TMO;
                end
                else if (status.is_tag)
                begin
                    state_next = S_ACK;
                end
                else
                begin
                    state_next = S_CMD_OUT;
                end
            end
            S_ACK:
            begin
                if (status.hit_ack)
                begin
                    cmd.clear_entry = 1'b1;
                    state_next = S_ACK_OUT;
                end
                else if (status.idx_last)
                begin
                    state_next = S_ACK_OUT;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_ACK_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.push = 1'b1;
                    cmd.sel = OSEL_ACK;
                    state_next = S_IDLE;
                end
            end
            S_CMD_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.push = 1'b1;
                    cmd.sel = OSEL_CMD;
                    state_next = S_CMD;
                end
            end
            S_CMD:
            begin
                if (status.hit_cmd)
                begin
                    cmd.store_entry = 1'b1;
                    state_next = S_IDLE;
                end
                else if (status.idx_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_TMO:
            begin
                // A resend candidate is held back in the pending register so that the final
                // beat of the scan can be marked last.
                if (status.tmo_resend && status.pend_valid && !status.out_free)
                begin
                    state_next = S_TMO;
                end
                else
                begin
                    if (status.tmo_drop)
                    begin
                        cmd.clear_entry = 1'b1;
                    end
                    else if (status.tmo_resend)
                    begin
                        cmd.take_pend = 1'b1;
                        if (status.pend_valid)
                        begin
                            cmd.push = 1'b1;
                            cmd.sel = OSEL_PEND_MID;
                        end
                    end
                    if (status.idx_last)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!status.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.push = 1'b1;
                    cmd.sel = OSEL_PEND_LAST;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/cmdrc_dpath.sv =====
// Datapath: entry registers, input latch, age compare and output register.
`timescale 1ns / 1ps

module cmdrc_dpath
    import cmdrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    cmdrc_in_if.sink    in_ch,
    cmdrc_out_if.source out_ch,
    input  dp_cmd_t     cmd,
    output dp_status_t  status
);

    logic [7:0]  drop_age_reg;
    logic [31:0] cmd_reg [ENTRIES];
    logic [31:0] time_reg [ENTRIES];
    idx_t        idx_reg;
    logic        kind_reg;
    logic [31:0] value_reg;
    logic [31:0] now_reg;
    logic        pend_valid_reg;
    logic [31:0] pend_word_reg;
    logic        out_valid_reg;
    logic        out_dest_reg;
    logic [31:0] out_word_reg;
    logic        out_last_reg;

    logic [31:0] cur_cmd;
    logic [31:0] cur_time;
    logic [31:0] age;
    logic        occupied;
    logic        too_old;

    assign cur_cmd  = cmd_reg[idx_reg];
    assign cur_time = time_reg[idx_reg];
    assign age      = now_reg - cur_time;
    assign occupied = (cur_time != 32'd0);
    assign too_old  = (age >= {24'd0, drop_age_reg});

    always_comb
    begin
        status.is_scan    = kind_reg;
        status.is_tag     = (value_reg < TAG_LIMIT);
        status.idx_last   = (idx_reg == LAST_IDX);
        status.hit_ack    = (cur_cmd[7:0] == value_reg[7:0]);
        status.hit_cmd    = (cur_cmd == value_reg) || !occupied;
        status.tmo_drop   = occupied && too_old;
        status.tmo_resend = occupied && !too_old && (age != 32'd0);
        status.pend_valid = pend_valid_reg;
        status.out_free   = !out_valid_reg || out_ch.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_age_reg   <= DROP_AGE_RESET;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                cmd_reg[i]  <= '0;
                time_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                drop_age_reg <= cfg_wr_data;
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + idx_t'(1);
            end
            if (cmd.clear_entry)
            begin
                cmd_reg[idx_reg]  <= '0;
                time_reg[idx_reg] <= '0;
            end
            else if (cmd.store_entry)
            begin
                cmd_reg[idx_reg]  <= value_reg;
                time_reg[idx_reg] <= now_reg;
            end
            if (cmd.take_pend)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.push && (cmd.sel == OSEL_PEND_LAST))
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= in_ch.kind;
            value_reg <= in_ch.value;
            now_reg   <= in_ch.now;
        end
        if (cmd.take_pend)
        begin
            pend_word_reg <= cur_cmd;
        end
        if (cmd.push)
        begin
            case (cmd.sel)
                OSEL_ACK:
                begin
                    out_dest_reg <= 1'b0;
                    out_word_reg <= value_reg;
                    out_last_reg <= 1'b1;
                end
                OSEL_CMD:
                begin
                    out_dest_reg <= 1'b1;
                    out_word_reg <= value_reg;
                    out_last_reg <= 1'b1;
                end
                OSEL_PEND_MID:
                begin
                    out_dest_reg <= 1'b1;
                    out_word_reg <= pend_word_reg;
                    out_last_reg <= 1'b0;
                end
                OSEL_PEND_LAST:
                begin
                    out_dest_reg <= 1'b1;
                    out_word_reg <= pend_word_reg;
                    out_last_reg <= 1'b1;
                end
                default:
                begin
                    out_dest_reg <= 1'b1;
                    out_word_reg <= pend_word_reg;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.dest  = out_dest_reg;
    assign out_ch.word  = out_word_reg;
    assign out_ch.last  = out_last_reg;

endmodule

// ===== rtl/core/command_retransmit_cache_top.sv =====
// Top level of the command retransmit cache.
//
// in_ch carries one beat per notification or timeout scan: kind, value, now.
// out_ch carries result beats: dest, word, last; last marks the final beat
// that an input beat causes. A scan with nothing to resend gives no beat.
// cfg_wr_en/cfg_wr_data write the 8-bit drop age; write only while idle.
// The block handles one input beat at a time. in_ch.ready is high only when
// the controller is idle. The walk visits one cache entry per cycle, save
// while a result beat that must be sent waits on a stalled receiver.
// Results sit in an output register, so a stalled receiver only holds the
// walk when a further beat must be sent; the next input beat may be taken
// while the last result still waits.
// Reset empties all entries and sets the drop age to 3.
`timescale 1ns / 1ps

module command_retransmit_cache_top
    import cmdrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    cmdrc_in_if.sink    in_ch,
    cmdrc_out_if.source out_ch
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    logic       in_ready;

    assign in_ch.ready = in_ready;

    cmdrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    cmdrc_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cmd         (dp_cmd),
        .status      (dp_status)
    );

endmodule

// ===== rtl/core/cmdrc_checker.sv =====
// Port-level checker for the retransmit cache and its bind to the top level.
`timescale 1ns / 1ps
`include "command_retransmit_cache_top_defines.svh"

module cmdrc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_dest,
    input logic [31:0] out_word,
    input logic        out_last
);

    // The block works on one beat at a time, so it is busy right after a take.
    `CMDRC_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

    // An acknowledge is always the single and final result of its beat.
    `CMDRC_ASSERT_SAME(a_ack_is_last, out_valid && (out_dest == 1'b0), out_last)

    // Acknowledge words are tags, which stay below 256.
    `CMDRC_ASSERT_SAME(a_ack_is_tag, out_valid && (out_dest == 1'b0), out_word[31:8] == 24'd0)

    // A stalled result beat holds.
    `CMDRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_word) && $stable(out_dest) && $stable(out_last))

endmodule

bind command_retransmit_cache_top cmdrc_checker u_cmdrc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_dest  (out_ch.dest),
    .out_word  (out_ch.word),
    .out_last  (out_ch.last)
);
